[rtl/bmq_pkg.sv]
// bmq_pkg: shared types and codes for the bounded message queue
// holds status, reject and request kind codes and the fixed field widths
// no dependencies
`default_nettype none

package bmq_pkg;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 6;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 3;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SENT      = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BYTE      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_TOO_SMALL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REJ_NONE = 2'd0,
    REJ_FULL = 2'd1,
    REJ_LONG = 2'd2
  } reject_t;

endpackage

`default_nettype wire

[rtl/bmq_ram.sv]
// bmq_ram: simple dual-port synchronous memory, one write and one read port
// read data is registered and holds while no read is enabled
// no dependencies
`default_nettype none

module bmq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/bounded_message_queue.sv]
// bounded_message_queue: ring of message slots with send and receive requests
// uses bmq_pkg for codes and widths and bmq_ram for byte and length storage
`default_nettype none

// usage
// - in_ channel carries requests: in_tuser is the kind (send byte or receive),
//   in_tlast marks the final byte of a sent message, in_tdata holds the byte
//   and the receive limit
// - out_ channel carries results: out_tuser is the status, out_tlast marks the
//   last result of a request, out_tdata holds the byte and the message length
// - a non-final send byte gives no result; a final send byte gives its status
//   in the output register next cycle
// - a receive on an empty queue gives an empty status with no memory read;
//   otherwise the length and first byte are read together; a message over the
//   limit is refused, else sent one byte per cycle from the single byte memory read port
// - requests are accepted in idle only; a non-final send byte is taken even
//   while a result waits in the output register, other requests need that
//   register free or draining
// - when the receiver stalls, delivery pauses and the byte memory read data
//   holds until the byte can be loaded
// - reset clears the slot pointers, fill level and the partial message; the
//   memories are not cleared since only committed slots are ever read

module bounded_message_queue
  import bmq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 8,
  parameter int MESSAGE_BYTES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [15:0]         in_tdata,  // payload_byte[7:0], receive_limit[13:8]
  input  wire logic                in_tuser,  // kind
  input  wire logic                in_tlast,  // final_byte
  // result channel
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [15:0]         out_tdata, // out_byte[7:0], message_length[13:8]
  output logic      [STATUS_W-1:0] out_tuser, // status
  output logic                     out_tlast  // end_of_run
);

  localparam int SW    = $clog2(QUEUE_DEPTH);
  localparam int IW    = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam int CW    = $clog2(MESSAGE_BYTES + 1);
  localparam int OW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {S_IDLE, S_RX_LEN, S_RX_DATA} state_t;

  // control state
  state_t          state_r, state_nxt;
  logic [SW-1:0]   wslot_r, wslot_nxt;
  logic [SW-1:0]   rslot_r, rslot_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  reject_t         rej_r, rej_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   len_r, len_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  // output register
  logic            out_vld_r;
  status_t         out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic            out_last_r;

  logic            out_load;
  status_t         ld_status;
  logic [BYTE_W-1:0] ld_byte;
  logic [LEN_W-1:0]  ld_len;
  logic            ld_last;

  // memory ports
  logic            byte_we, byte_re;
  logic [SW+IW-1:0] byte_waddr, byte_raddr;
  logic [BYTE_W-1:0] byte_rdata;
  logic            len_we, len_re;
  logic [SW-1:0]   len_waddr;
  logic [CW-1:0]   len_wdata, len_rdata;

  logic            out_free, in_acc;
  logic [BYTE_W-1:0] in_byte;
  logic [LIMIT_W-1:0] in_limit;
  logic [CW-1:0]   cnt_inc, idx_inc;
  reject_t         rej_eff;
  logic            msg_last;

  assign in_byte  = in_tdata[7:0];
  assign in_limit = in_tdata[13:8];
  assign out_free = !out_vld_r || out_tready;

  // a non-final send byte never produces a result
  assign in_tready = (state_r == S_IDLE) &&
                     (out_free || ((in_tuser == KIND_SEND) && !in_tlast));
  assign in_acc    = in_tvalid && in_tready;

  assign cnt_inc  = cnt_r + CW'(1);
  assign idx_inc  = CW'(idx_r) + CW'(1);
  assign msg_last = (idx_inc == len_r);

  always_comb begin
    state_nxt  = state_r;
    wslot_nxt  = wslot_r;
    rslot_nxt  = rslot_r;
    occ_nxt    = occ_r;
    cnt_nxt    = cnt_r;
    rej_nxt    = rej_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    limit_nxt  = limit_r;
    out_load   = 1'b0;
    ld_status  = ST_SENT;
    ld_byte    = '0;
    ld_len     = '0;
    ld_last    = 1'b0;
    byte_we    = 1'b0;
    byte_waddr = {wslot_r, cnt_r[IW-1:0]};
    byte_re    = 1'b0;
    byte_raddr = {rslot_r, idx_r};
    len_we     = 1'b0;
    len_waddr  = wslot_r;
    len_wdata  = cnt_inc;
    len_re     = 1'b0;
    rej_eff    = rej_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_SEND)) begin
          // full verdict is latched on the first byte of a message
          if (cnt_r == '0) begin
            rej_eff = (occ_r == OW'(QUEUE_DEPTH)) ? REJ_FULL : REJ_NONE;
          end
          if (cnt_r < CW'(MESSAGE_BYTES)) begin
            byte_we = (rej_eff == REJ_NONE);
            cnt_nxt = cnt_inc;
          end else if (rej_eff == REJ_NONE) begin
            rej_eff = REJ_LONG;
          end
          rej_nxt = rej_eff;
          if (in_tlast) begin
            out_load = 1'b1;
            ld_last  = 1'b1;
            unique case (rej_eff)
              REJ_FULL: ld_status = ST_FULL;
              REJ_LONG: ld_status = ST_TOO_LONG;
              default: begin
                ld_status = ST_SENT;
                ld_len    = LEN_W'(cnt_inc);
                len_we    = 1'b1;
                wslot_nxt = (wslot_r == SW'(QUEUE_DEPTH - 1)) ? '0 : wslot_r + SW'(1);
                occ_nxt   = occ_r + OW'(1);
              end
            endcase
            cnt_nxt = '0;
            rej_nxt = REJ_NONE;
          end
        end else if (in_acc) begin
          if (occ_r == '0) begin
            out_load  = 1'b1;
            ld_status = ST_EMPTY;
            ld_last   = 1'b1;
          end else begin
            // fetch the head length and its first byte together
            len_re     = 1'b1;
            byte_re    = 1'b1;
            byte_raddr = {rslot_r, IW'(0)};
            idx_nxt    = '0;
            limit_nxt  = in_limit;
            state_nxt  = S_RX_LEN;
          end
        end
      end

      S_RX_LEN: begin
        if (out_free) begin
          if (CMP_W'(len_rdata) > CMP_W'(limit_r)) begin
            out_load  = 1'b1;
            ld_status = ST_TOO_SMALL;
            ld_last   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            len_nxt   = len_rdata;
            state_nxt = S_RX_DATA;
          end
        end
      end

      S_RX_DATA: begin
        // read data holds while the output register is busy
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_BYTE;
          ld_byte   = byte_rdata;
          ld_len    = LEN_W'(len_r);
          ld_last   = msg_last;
          if (msg_last) begin
            rslot_nxt = (rslot_r == SW'(QUEUE_DEPTH - 1)) ? '0 : rslot_r + SW'(1);
            occ_nxt   = occ_r - OW'(1);
            state_nxt = S_IDLE;
          end else begin
            idx_nxt    = idx_inc[IW-1:0];
            byte_re    = 1'b1;
            byte_raddr = {rslot_r, idx_inc[IW-1:0]};
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wslot_r   <= '0;
      rslot_r   <= '0;
      occ_r     <= '0;
      cnt_r     <= '0;
      rej_r     <= REJ_NONE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wslot_r <= wslot_nxt;
      rslot_r <= rslot_nxt;
      occ_r   <= occ_nxt;
      cnt_r   <= cnt_nxt;
      rej_r   <= rej_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    limit_r <= limit_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_byte_r   <= ld_byte;
      out_len_r    <= ld_len;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_len_r, out_byte_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // message bytes, one slot of 2**IW entries per queue position
  bmq_ram #(
    .DATA_W(BYTE_W),
    .ADDR_W(SW + IW)
  ) u_byte_ram (
    .clk  (clk),
    .we   (byte_we),
    .waddr(byte_waddr),
    .wdata(in_byte),
    .re   (byte_re),
    .raddr(byte_raddr),
    .rdata(byte_rdata)
  );

  // committed message lengths, one per slot
  bmq_ram #(
    .DATA_W(CW),
    .ADDR_W(SW)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .re   (len_re),
    .raddr(rslot_r),
    .rdata(len_rdata)
  );

endmodule

`default_nettype wire
